[sv/lft_pkg.sv]
// ----------------------------------------------------------------------------
// lft_pkg
// Shared types, codes and helper functions for the link failsafe and
// telemetry filter.
// ----------------------------------------------------------------------------
package lft_pkg;

   localparam int TIME_BITS  = 32;
   localparam int HALF_BITS  = TIME_BITS / 2;
   localparam int RECIP_BITS = TIME_BITS + 1;
   localparam int PP_BITS    = HALF_BITS + RECIP_BITS;
   localparam int PCT_BITS   = 7;
   localparam int LVL_BITS   = 8;
   localparam int BATT_BITS  = 16;
   localparam int CSR_BITS   = 16;
   localparam int IDX_BITS   = 3;

   // link states
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_CONNECTING = 3'd1;
   localparam logic [2:0] ST_CONNECTED  = 3'd2;
   localparam logic [2:0] ST_LOST       = 3'd3;
   localparam logic [2:0] ST_RADIO_ERR  = 3'd4;

   // link colors
   localparam logic [2:0] COL_OFF    = 3'd0;
   localparam logic [2:0] COL_YELLOW = 3'd1;
   localparam logic [2:0] COL_BLUE   = 3'd2;
   localparam logic [2:0] COL_GREEN  = 3'd3;
   localparam logic [2:0] COL_RED    = 3'd4;

   // register indexes
   localparam logic [IDX_BITS-1:0] CSR_RADIO_READY = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_TX_PERIOD   = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_LED_PERIOD  = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_RX_TIMEOUT  = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_EMA_SHIFT   = 3'd4;
   localparam logic [IDX_BITS-1:0] CSR_SNAP_LOW    = 3'd5;
   localparam logic [IDX_BITS-1:0] CSR_SNAP_HIGH   = 3'd6;

   localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

   // pct * 255 / 100 as pct * (255 * ceil(2^19 / 100)) >> 19, exact for 0..100
   localparam logic [20:0] LEVEL_MULT  = 21'd1336965;
   localparam int          LEVEL_SHIFT = 19;

   typedef struct packed {
      logic        radio_ready;
      logic [9:0]  tx_period_ms;
      logic [9:0]  led_period_ms;
      logic [15:0] ack_timeout_ms;
      logic [2:0]  smooth_shift;
      logic [6:0]  snap_low;
      logic [6:0]  snap_high;
   } cfg_type;

   typedef struct packed {
      logic [2:0] state;
      logic       tx_due;
      logic       ack_got;
      logic       target_zero;
   } link_status_type;

   // clamp to 100, then snap both ends
   function automatic logic [PCT_BITS-1:0] snap_batt(input logic [BATT_BITS-1:0] raw,
                                                    input logic [PCT_BITS-1:0] lo,
                                                    input logic [PCT_BITS-1:0] hi);
      logic [PCT_BITS-1:0] v;
      v = (raw > BATT_BITS'(PCT_FULL)) ? PCT_FULL : raw[PCT_BITS-1:0];
      if (v < lo) v = '0;
      if (v > hi) v = PCT_FULL;
      return v;
   endfunction

   function automatic logic [PCT_BITS-1:0] mid3(input logic [PCT_BITS-1:0] x,
                                               input logic [PCT_BITS-1:0] y,
                                               input logic [PCT_BITS-1:0] z);
      logic [PCT_BITS-1:0] lo;
      logic [PCT_BITS-1:0] hi;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      if (z <= lo) return lo;
      if (z >= hi) return hi;
      return z;
   endfunction

   function automatic logic [LVL_BITS-1:0] pct_to_level(input logic [PCT_BITS-1:0] p);
      logic [27:0] prod;
      prod = 28'(p) * 28'(LEVEL_MULT);
      return prod[LEVEL_SHIFT +: LVL_BITS];
   endfunction

endpackage

[sv/lft_front.sv]
// ----------------------------------------------------------------------------
// lft_front
// Input register with handshake; also holds the partial products of the
// timestamp reciprocal multiply that yields the blink phase.
// ----------------------------------------------------------------------------
module lft_front import lft_pkg::*; #(
   parameter logic [RECIP_BITS-1:0] RECIP     = 33'd17179870,
   parameter int                    BLINK_BIT = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TIME_BITS-1:0] req_now_ms,
   input  logic                 req_link_enabled,
   input  logic                 req_ack_ok,
   input  logic [BATT_BITS-1:0] req_ack_batt,
   input  logic                 advance,
   output logic                 item_valid,
   output logic [TIME_BITS-1:0] item_now,
   output logic                 item_enabled,
   output logic                 item_ack,
   output logic [BATT_BITS-1:0] item_batt,
   output logic                 item_blink_on
);

   logic                 vld_ff, vld_in;
   logic                 load;
   logic [TIME_BITS-1:0] now_ff;
   logic                 en_ff;
   logic                 ack_ff;
   logic [BATT_BITS-1:0] batt_ff;
   logic [PP_BITS-1:0]   pp_lo_ff, pp_lo_in;
   logic [PP_BITS-1:0]   pp_hi_ff, pp_hi_in;
   logic [PP_BITS+HALF_BITS-1:0] prod;

   // hold the input while the held item cannot move on
   assign req_stall = vld_ff && !advance;
   assign load      = req_valid && !req_stall;

   // split now * RECIP into two half-width products
   assign pp_lo_in = PP_BITS'(req_now_ms[HALF_BITS-1:0]) * PP_BITS'(RECIP);
   assign pp_hi_in = PP_BITS'(req_now_ms[TIME_BITS-1:HALF_BITS]) * PP_BITS'(RECIP);

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         now_ff   <= req_now_ms;
         en_ff    <= req_link_enabled;
         ack_ff   <= req_ack_ok;
         batt_ff  <= req_ack_batt;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
   end

   // combine the products; bit BLINK_BIT is the parity of now / half period
   assign prod = {{HALF_BITS{1'b0}}, pp_lo_ff} + {pp_hi_ff, {HALF_BITS{1'b0}}};

   assign item_valid    = vld_ff;
   assign item_now      = now_ff;
   assign item_enabled  = en_ff;
   assign item_ack      = ack_ff;
   assign item_batt     = batt_ff;
   assign item_blink_on = !prod[BLINK_BIT];

endmodule

[sv/lft_link.sv]
// ----------------------------------------------------------------------------
// lft_link
// Link state machine: enable edges, transmit slot pacing and the
// acknowledge failsafe timer.
// ----------------------------------------------------------------------------
module lft_link import lft_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cfg_type              cfg,
   input  logic [TIME_BITS-1:0] now,
   input  logic                 enabled,
   input  logic                 ack,
   output link_status_type      status
);

   logic [2:0]           state_ff, state_in;
   logic                 en_prev_ff, en_prev_in;
   logic [TIME_BITS-1:0] last_tx_ff, last_tx_in;
   logic [TIME_BITS-1:0] last_ack_ff, last_ack_in;
   logic [TIME_BITS-1:0] tx_elapsed;
   logic [TIME_BITS-1:0] ack_elapsed;
   logic                 slot;
   logic                 timed_out;
   logic                 rise;
   logic                 due;
   logic                 got;

   assign tx_elapsed  = now - last_tx_ff;
   assign ack_elapsed = now - last_ack_ff;
   assign slot        = tx_elapsed >= TIME_BITS'(cfg.tx_period_ms);
   assign timed_out   = ack_elapsed > TIME_BITS'(cfg.ack_timeout_ms);

   // next link state for this pass
   always_comb begin
      state_in    = state_ff;
      en_prev_in  = en_prev_ff;
      last_tx_in  = last_tx_ff;
      last_ack_in = last_ack_ff;
      rise        = 1'b0;
      due         = 1'b0;
      got         = 1'b0;

      // follow enable edges
      priority if (!cfg.radio_ready) begin
         en_prev_in = 1'b0;
      end else if (enabled != en_prev_ff) begin
         en_prev_in = enabled;
         if (enabled) begin
            rise        = 1'b1;
            last_ack_in = now;
            state_in    = ST_CONNECTING;
         end else begin
            state_in = ST_IDLE;
         end
      end else begin
         state_in = state_ff;
      end

      // slot, acknowledge and failsafe
      priority if (!cfg.radio_ready) begin
         state_in = ST_RADIO_ERR;
      end else if (!en_prev_in) begin
         state_in = ST_IDLE;
      end else begin
         if (slot) begin
            due        = 1'b1;
            last_tx_in = now;
            if (ack) begin
               got         = 1'b1;
               last_ack_in = now;
               state_in    = ST_CONNECTED;
            end
         end
         if (!got && !rise && state_in == ST_CONNECTED && timed_out) begin
            state_in = ST_LOST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         en_prev_ff  <= 1'b0;
         last_tx_ff  <= '0;
         last_ack_ff <= '0;
      end else if (advance) begin
         state_ff    <= state_in;
         en_prev_ff  <= en_prev_in;
         last_tx_ff  <= last_tx_in;
         last_ack_ff <= last_ack_in;
      end
   end

   assign status.state       = state_in;
   assign status.tx_due      = due;
   assign status.ack_got     = got;
   assign status.target_zero = !en_prev_in || (timed_out && !got && !rise);

endmodule

[sv/lft_batt.sv]
// ----------------------------------------------------------------------------
// lft_batt
// Battery telemetry path: snap, median-of-3 target, LED tick with EMA
// smoothing, level mapping and link color.
// ----------------------------------------------------------------------------
module lft_batt import lft_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cfg_type              cfg,
   input  logic [TIME_BITS-1:0] now,
   input  logic [BATT_BITS-1:0] batt,
   input  logic                 blink_on,
   input  link_status_type      status,
   output logic [PCT_BITS-1:0]  target_pct,
   output logic [PCT_BITS-1:0]  smooth_pct,
   output logic [LVL_BITS-1:0]  level,
   output logic [2:0]           color
);

   logic [PCT_BITS-1:0]  hist_ff [3];
   logic [PCT_BITS-1:0]  hist_in [3];
   logic                 hist_vld_ff, hist_vld_in;
   logic [PCT_BITS-1:0]  target_ff, target_in;
   logic [PCT_BITS-1:0]  smooth_ff, smooth_in;
   logic [LVL_BITS-1:0]  level_ff, level_in;
   logic [2:0]           color_ff, color_in;
   logic [TIME_BITS-1:0] last_led_ff, last_led_in;
   logic [PCT_BITS-1:0]  snapped;
   logic [PCT_BITS-1:0]  tgt;
   logic [PCT_BITS-1:0]  diff;
   logic [LVL_BITS-1:0]  down_step;
   logic [LVL_BITS-1:0]  round_add;
   logic [PCT_BITS-1:0]  smooth_raw;
   logic                 tick;

   assign snapped = snap_batt(batt, cfg.snap_low, cfg.snap_high);
   assign tick    = (now - last_led_ff) >= TIME_BITS'(cfg.led_period_ms);

   // shift the history on a counted acknowledge
   always_comb begin
      hist_in[0]  = hist_ff[0];
      hist_in[1]  = hist_ff[1];
      hist_in[2]  = hist_ff[2];
      hist_vld_in = hist_vld_ff;
      if (status.ack_got) begin
         hist_vld_in = 1'b1;
         hist_in[2]  = snapped;
         if (hist_vld_ff) begin
            hist_in[0] = hist_ff[1];
            hist_in[1] = hist_ff[2];
         end else begin
            hist_in[0] = snapped;
            hist_in[1] = snapped;
         end
      end
   end

   assign tgt       = status.ack_got ? mid3(hist_in[0], hist_in[1], hist_in[2]) : target_ff;
   assign round_add = (LVL_BITS'(1) << cfg.smooth_shift) - LVL_BITS'(1);

   // LED tick: failsafe target, EMA step, level and color
   always_comb begin
      target_in   = tgt;
      smooth_in   = smooth_ff;
      level_in    = level_ff;
      color_in    = color_ff;
      last_led_in = last_led_ff;
      diff        = '0;
      down_step   = '0;
      smooth_raw  = smooth_ff;
      if (tick) begin
         last_led_in = now;
         if (status.target_zero) begin
            target_in = '0;
         end
         if (target_in >= smooth_ff) begin
            diff       = target_in - smooth_ff;
            smooth_raw = smooth_ff + (diff >> cfg.smooth_shift);
         end else begin
            diff       = smooth_ff - target_in;
            down_step  = (LVL_BITS'(diff) + round_add) >> cfg.smooth_shift;
            smooth_raw = smooth_ff - down_step[PCT_BITS-1:0];
         end
         smooth_in = (smooth_raw > PCT_FULL) ? PCT_FULL : smooth_raw;
         level_in  = pct_to_level(smooth_in);
         unique case (status.state)
            ST_IDLE:       color_in = COL_YELLOW;
            ST_CONNECTING: color_in = blink_on ? COL_BLUE : COL_OFF;
            ST_CONNECTED:  color_in = COL_GREEN;
            ST_LOST:       color_in = blink_on ? COL_RED : COL_OFF;
            default:       color_in = COL_RED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff[0]  <= '0;
         hist_ff[1]  <= '0;
         hist_ff[2]  <= '0;
         hist_vld_ff <= 1'b0;
         target_ff   <= '0;
         smooth_ff   <= '0;
         level_ff    <= '0;
         color_ff    <= COL_OFF;
         last_led_ff <= '0;
      end else if (advance) begin
         hist_ff[0]  <= hist_in[0];
         hist_ff[1]  <= hist_in[1];
         hist_ff[2]  <= hist_in[2];
         hist_vld_ff <= hist_vld_in;
         target_ff   <= target_in;
         smooth_ff   <= smooth_in;
         level_ff    <= level_in;
         color_ff    <= color_in;
         last_led_ff <= last_led_in;
      end
   end

   assign target_pct = target_ff;
   assign smooth_pct = smooth_ff;
   assign level      = level_ff;
   assign color      = color_ff;

endmodule

[sv/link_failsafe_telemetry_filter.sv]
// Flow: an accepted request sits in the input register; its pass results
// are registered as the response when the response slot is free or taken.
// Throughput: one request per cycle while the response is not stalled; the
// state update of one pass is combinational compare, median and shift logic.
// Reset: synchronous; link idle, all times, history and outputs zero,
// registers at their defaults.
// ----------------------------------------------------------------------------
// link_failsafe_telemetry_filter
// Link state tracking, transmit slot pacing and battery telemetry filtering,
// one control loop pass per request.
// ----------------------------------------------------------------------------
module link_failsafe_telemetry_filter import lft_pkg::*; #(
   parameter int BLINK_HALF_MS = 250
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [IDX_BITS-1:0]  csr_index,
   input  logic [CSR_BITS-1:0]  csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TIME_BITS-1:0] req_now_ms,
   input  logic                 req_link_enabled,
   input  logic                 req_ack_ok,
   input  logic [BATT_BITS-1:0] req_ack_batt,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_link_state,
   output logic                 rsp_tx_due,
   output logic [PCT_BITS-1:0]  rsp_target_pct,
   output logic [PCT_BITS-1:0]  rsp_smooth_pct,
   output logic [LVL_BITS-1:0]  rsp_battery_level,
   output logic [2:0]           rsp_link_color
);

   // reciprocal for floor(now / BLINK_HALF_MS), exact over the full time range
   localparam int          BLINK_LOG  = $clog2(BLINK_HALF_MS);
   localparam int          BLINK_BIT  = TIME_BITS + BLINK_LOG;
   localparam logic [63:0] RECIP_FULL = (64'd1 << BLINK_BIT) / 64'(BLINK_HALF_MS) + 64'd1;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];

   cfg_type              cfg_ff;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 tx_due_ff;
   logic [2:0]           link_state_ff;
   logic                 advance;
   logic                 item_valid;
   logic [TIME_BITS-1:0] item_now;
   logic                 item_enabled;
   logic                 item_ack;
   logic [BATT_BITS-1:0] item_batt;
   logic                 item_blink_on;
   link_status_type      status;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radio_ready    <= 1'b0;
         cfg_ff.tx_period_ms   <= 10'd20;
         cfg_ff.led_period_ms  <= 10'd10;
         cfg_ff.ack_timeout_ms <= 16'd120;
         cfg_ff.smooth_shift   <= 3'd2;
         cfg_ff.snap_low       <= 7'd1;
         cfg_ff.snap_high      <= 7'd99;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIO_READY: cfg_ff.radio_ready    <= csr_data[0];
            CSR_TX_PERIOD:   cfg_ff.tx_period_ms   <= csr_data[9:0];
            CSR_LED_PERIOD:  cfg_ff.led_period_ms  <= csr_data[9:0];
            CSR_RX_TIMEOUT:  cfg_ff.ack_timeout_ms <= csr_data[15:0];
            CSR_EMA_SHIFT:   cfg_ff.smooth_shift   <= csr_data[2:0];
            CSR_SNAP_LOW:    cfg_ff.snap_low       <= csr_data[6:0];
            CSR_SNAP_HIGH:   cfg_ff.snap_high      <= csr_data[6:0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   // advance the held request when the response slot is free or being taken
   assign advance = item_valid && (!rsp_vld_ff || !rsp_stall);

   lft_front #(
      .RECIP     (RECIP),
      .BLINK_BIT (BLINK_BIT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_ms       (req_now_ms),
      .req_link_enabled (req_link_enabled),
      .req_ack_ok       (req_ack_ok),
      .req_ack_batt     (req_ack_batt),
      .advance          (advance),
      .item_valid       (item_valid),
      .item_now         (item_now),
      .item_enabled     (item_enabled),
      .item_ack         (item_ack),
      .item_batt        (item_batt),
      .item_blink_on    (item_blink_on)
   );

   lft_link u_link (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .now     (item_now),
      .enabled (item_enabled),
      .ack     (item_ack),
      .status  (status)
   );

   lft_batt u_batt (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg_ff),
      .now        (item_now),
      .batt       (item_batt),
      .blink_on   (item_blink_on),
      .status     (status),
      .target_pct (rsp_target_pct),
      .smooth_pct (rsp_smooth_pct),
      .level      (rsp_battery_level),
      .color      (rsp_link_color)
   );

   // response valid and the per-pass fields
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff    <= 1'b0;
         tx_due_ff     <= 1'b0;
         link_state_ff <= ST_IDLE;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            tx_due_ff     <= status.tx_due;
            link_state_ff <= status.state;
         end
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_tx_due     = tx_due_ff;
   assign rsp_link_state = link_state_ff;

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stall) |-> !advance)
      else $error("pass advanced over a stalled response");

   // radio not ready forces the error state
   a_radio_err: assert property (@(posedge clock) disable iff (reset)
      (advance && !cfg_ff.radio_ready) |=> (rsp_link_state == ST_RADIO_ERR))
      else $error("radio not ready but link state not radio error");

   // a transmit slot only while the link is enabled
   a_slot_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_tx_due) |->
         (rsp_link_state != ST_IDLE && rsp_link_state != ST_RADIO_ERR))
      else $error("transmit slot in idle or radio error state");

   // smoothed percent stays in range
   a_smooth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_smooth_pct <= PCT_FULL)
      else $error("smoothed percent above full scale");

endmodule
